// ===== hdl/tbs_pkg.sv =====
// Types, constants and helper functions for the token boundary scanner.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package tbs_pkg;

   localparam int POS_BITS = 16;
   localparam int LEN_BITS = 12;
   localparam int KIND_BITS = 4;
   localparam int MODE_BITS = 4;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;
   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
   localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

   // scan modes
   localparam logic [MODE_BITS-1:0] MODE_IDLE     = 4'd0;
   localparam logic [MODE_BITS-1:0] MODE_INT      = 4'd1;
   localparam logic [MODE_BITS-1:0] MODE_FLOAT    = 4'd2;
   localparam logic [MODE_BITS-1:0] MODE_STRING   = 4'd3;
   localparam logic [MODE_BITS-1:0] MODE_ESCAPE   = 4'd4;
   localparam logic [MODE_BITS-1:0] MODE_IDENT    = 4'd5;
   localparam logic [MODE_BITS-1:0] MODE_LCOMMENT = 4'd6;
   localparam logic [MODE_BITS-1:0] MODE_BCOMMENT = 4'd7;
   localparam logic [MODE_BITS-1:0] MODE_ERROR    = 4'd8;

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_INT      = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_FLOAT    = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_STRING   = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_IDENT    = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_OPER     = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_NUMERR   = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_IDERR    = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_UNCLOSED = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_BADCHAR  = 4'd10;

   // identifier prefixes
   localparam logic [1:0] PREFIX_PLAIN   = 2'd0;
   localparam logic [1:0] PREFIX_LABEL   = 2'd1;
   localparam logic [1:0] PREFIX_BUILTIN = 2'd2;

   // special characters
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_AT        = 8'h40;
   localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_LF        = 8'h0A;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] token_kind;
      logic [POS_BITS-1:0]  start_line;
      logic [POS_BITS-1:0]  start_column;
      logic [LEN_BITS-1:0]  token_length;
      logic                 last_of_run;
   } rsp_type;

   // results produced by one request: zero, one or two
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } emit_type;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D)
                 || (c == 8'h0B) || (c == 8'h0C);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // single-character operators: & | ! - + / % * ( ) [ ] $ < > ~
   function automatic logic is_oper(input logic [7:0] c);
      case (c)
         8'h26, 8'h7C, 8'h21, 8'h2D, 8'h2B, 8'h2F, 8'h25, 8'h2A,
         8'h28, 8'h29, 8'h5B, 8'h5D, 8'h24, 8'h3C, 8'h3E, 8'h7E: is_oper = 1'b1;
         default: is_oper = 1'b0;
      endcase
   endfunction

   function automatic logic [POS_BITS-1:0] sat_pos(input logic [POS_BITS-1:0] v);
      sat_pos = (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [LEN_BITS-1:0] sat_len(input logic [LEN_BITS-1:0] v);
      sat_len = (v == LEN_MAX) ? v : v + 1'b1;
   endfunction

   function automatic rsp_type make_rsp(
      input logic [KIND_BITS-1:0] kind,
      input logic [POS_BITS-1:0]  line,
      input logic [POS_BITS-1:0]  col,
      input logic [LEN_BITS-1:0]  len,
      input logic                 last
   );
      rsp_type r;
      r.token_kind   = kind;
      r.start_line   = line;
      r.start_column = col;
      r.token_length = len;
      r.last_of_run  = last;
      make_rsp = r;
   endfunction

endpackage

// ===== hdl/token_boundary_scanner.sv =====
// Token boundary scanner, top level: input register, scanner core, result queue.
// Depends on tbs_pkg, tbs_core and tbs_rsp_fifo.
// A request accepted into the input register is scanned from there; its results are written
// into the queue and handed out from its head. Throughput: one request per cycle while
// the queue holds at most two results; two-result requests or a stalled output back it up.
// Reset (synchronous): scanner idle at line 1, column 1; input register and queue empty.
module token_boundary_scanner (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tbs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbs_pkg::rsp_type rsp_payload
);

   logic              in_vld_ff, in_vld_in;
   tbs_pkg::req_type  in_item_ff;
   logic              room;
   logic              core_go;
   tbs_pkg::emit_type emit;

   assign core_go   = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // hold the request while the queue lacks space
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
   end

   tbs_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (core_go),
      .item  (in_item_ff),
      .emit  (emit)
   );

   tbs_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (emit),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hdl/tbs_core.sv =====
// Scanner state and per-character classification for the token boundary scanner.
// Depends on tbs_pkg for types, mode and kind codes, and character helpers.
module tbs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  tbs_pkg::req_type  item,
   output tbs_pkg::emit_type emit
);

   logic [tbs_pkg::MODE_BITS-1:0] mode_ff, mode_in;
   logic                          quote_single_ff, quote_single_in;
   logic [1:0]                    prefix_ff, prefix_in;
   logic [tbs_pkg::POS_BITS-1:0]  tok_line_ff, tok_line_in;
   logic [tbs_pkg::POS_BITS-1:0]  tok_col_ff, tok_col_in;
   logic [tbs_pkg::LEN_BITS-1:0]  tok_len_ff, tok_len_in;
   logic [tbs_pkg::POS_BITS-1:0]  cur_line_ff, cur_line_in;
   logic [tbs_pkg::POS_BITS-1:0]  cur_col_ff, cur_col_in;

   logic [7:0]                    c;
   logic [tbs_pkg::LEN_BITS-1:0]  len_next;
   logic [tbs_pkg::KIND_BITS-1:0] word_kind;
   logic                          c_space, c_oper, c_digit, c_letter;
   logic                          ident_char;

   always_comb begin
      c        = item.char_in;
      c_space  = tbs_pkg::is_space(c);
      c_oper   = tbs_pkg::is_oper(c);
      c_digit  = tbs_pkg::is_digit(c);
      c_letter = tbs_pkg::is_letter(c);
      ident_char = c_digit || c_letter || (c == tbs_pkg::CHAR_UNDERLINE);
      len_next = tbs_pkg::sat_len(tok_len_ff);

      if (mode_ff == tbs_pkg::MODE_INT) begin
         word_kind = tbs_pkg::KIND_INT;
      end else if (mode_ff == tbs_pkg::MODE_FLOAT) begin
         word_kind = tbs_pkg::KIND_FLOAT;
      end else if (prefix_ff == tbs_pkg::PREFIX_LABEL
                   || prefix_ff == tbs_pkg::PREFIX_BUILTIN) begin
         word_kind = tbs_pkg::KIND_IDENT + {2'b00, prefix_ff};
      end else begin
         word_kind = tbs_pkg::KIND_IDENT;
      end
   end

   always_comb begin
      mode_in         = mode_ff;
      quote_single_in = quote_single_ff;
      prefix_in       = prefix_ff;
      tok_line_in     = tok_line_ff;
      tok_col_in      = tok_col_ff;
      tok_len_in      = tok_len_ff;
      cur_line_in     = cur_line_ff;
      cur_col_in      = cur_col_ff;
      emit            = '0;

      if (go && mode_ff != tbs_pkg::MODE_ERROR) begin
         if (item.end_of_input) begin
            case (mode_ff)
               tbs_pkg::MODE_INT, tbs_pkg::MODE_FLOAT, tbs_pkg::MODE_IDENT: begin
                  emit.count = 2'd1;
                  emit.first = tbs_pkg::make_rsp(word_kind, tok_line_ff, tok_col_ff,
                                                 tok_len_ff, 1'b1);
                  mode_in = tbs_pkg::MODE_IDLE;
               end
               tbs_pkg::MODE_STRING, tbs_pkg::MODE_ESCAPE: begin
                  emit.count = 2'd1;
                  emit.first = tbs_pkg::make_rsp(tbs_pkg::KIND_UNCLOSED, tok_line_ff,
                                                 tok_col_ff, tok_len_ff, 1'b1);
                  mode_in = tbs_pkg::MODE_ERROR;
               end
               default: begin
                  mode_in = tbs_pkg::MODE_IDLE;
               end
            endcase
         end else begin
            case (mode_ff)
               tbs_pkg::MODE_INT, tbs_pkg::MODE_FLOAT, tbs_pkg::MODE_IDENT: begin
                  if (c_space || c_oper) begin
                     mode_in = tbs_pkg::MODE_IDLE;
                     if (c_oper) begin
                        emit.count  = 2'd2;
                        emit.first  = tbs_pkg::make_rsp(word_kind, tok_line_ff, tok_col_ff,
                                                        tok_len_ff, 1'b0);
                        emit.second = tbs_pkg::make_rsp(tbs_pkg::KIND_OPER, cur_line_ff,
                                                        cur_col_ff, tbs_pkg::LEN_ONE, 1'b1);
                     end else begin
                        emit.count = 2'd1;
                        emit.first = tbs_pkg::make_rsp(word_kind, tok_line_ff, tok_col_ff,
                                                       tok_len_ff, 1'b1);
                     end
                  end else if ((mode_ff == tbs_pkg::MODE_IDENT) ? ident_char : c_digit) begin
                     tok_len_in = len_next;
                  end else if (mode_ff == tbs_pkg::MODE_INT && c == tbs_pkg::CHAR_DOT) begin
                     tok_len_in = len_next;
                     mode_in    = tbs_pkg::MODE_FLOAT;
                  end else begin
                     // offending character counts toward the error record
                     tok_len_in = len_next;
                     emit.count = 2'd1;
                     emit.first = tbs_pkg::make_rsp(
                        (mode_ff == tbs_pkg::MODE_IDENT) ? tbs_pkg::KIND_IDERR
                                                         : tbs_pkg::KIND_NUMERR,
                        tok_line_ff, tok_col_ff, len_next, 1'b1);
                     mode_in = tbs_pkg::MODE_ERROR;
                  end
               end
               tbs_pkg::MODE_STRING: begin
                  if (c == tbs_pkg::CHAR_BACKSLASH) begin
                     mode_in = tbs_pkg::MODE_ESCAPE;
                  end else begin
                     tok_len_in = len_next;
                     if (c == (quote_single_ff ? tbs_pkg::CHAR_SQUOTE : tbs_pkg::CHAR_DQUOTE)) begin
                        emit.count = 2'd1;
                        emit.first = tbs_pkg::make_rsp(tbs_pkg::KIND_STRING, tok_line_ff,
                                                       tok_col_ff, len_next, 1'b1);
                        mode_in = tbs_pkg::MODE_IDLE;
                     end
                  end
               end
               tbs_pkg::MODE_ESCAPE: begin
                  tok_len_in = len_next;
                  mode_in    = tbs_pkg::MODE_STRING;
               end
               tbs_pkg::MODE_LCOMMENT: begin
                  if (c == tbs_pkg::CHAR_LF) begin
                     mode_in = tbs_pkg::MODE_IDLE;
                  end
               end
               tbs_pkg::MODE_BCOMMENT: begin
                  if (c == tbs_pkg::CHAR_QUESTION) begin
                     mode_in = tbs_pkg::MODE_IDLE;
                  end
               end
               default: begin
                  if (c_space) begin
                     mode_in = tbs_pkg::MODE_IDLE;
                  end else if (c == tbs_pkg::CHAR_HASH) begin
                     mode_in = tbs_pkg::MODE_LCOMMENT;
                  end else if (c == tbs_pkg::CHAR_QUESTION) begin
                     mode_in = tbs_pkg::MODE_BCOMMENT;
                  end else if (c_digit) begin
                     mode_in     = tbs_pkg::MODE_INT;
                     tok_line_in = cur_line_ff;
                     tok_col_in  = cur_col_ff;
                     tok_len_in  = tbs_pkg::LEN_ONE;
                  end else if (c_letter || c == tbs_pkg::CHAR_AT
                               || c == tbs_pkg::CHAR_UNDERLINE) begin
                     mode_in     = tbs_pkg::MODE_IDENT;
                     tok_line_in = cur_line_ff;
                     tok_col_in  = cur_col_ff;
                     tok_len_in  = tbs_pkg::LEN_ONE;
                     if (c == tbs_pkg::CHAR_AT) begin
                        prefix_in = tbs_pkg::PREFIX_LABEL;
                     end else if (c == tbs_pkg::CHAR_UNDERLINE) begin
                        prefix_in = tbs_pkg::PREFIX_BUILTIN;
                     end else begin
                        prefix_in = tbs_pkg::PREFIX_PLAIN;
                     end
                  end else if (c == tbs_pkg::CHAR_DQUOTE || c == tbs_pkg::CHAR_SQUOTE) begin
                     mode_in         = tbs_pkg::MODE_STRING;
                     tok_line_in     = cur_line_ff;
                     tok_col_in      = cur_col_ff;
                     tok_len_in      = tbs_pkg::LEN_ONE;
                     quote_single_in = (c == tbs_pkg::CHAR_SQUOTE);
                  end else if (c_oper) begin
                     mode_in    = tbs_pkg::MODE_IDLE;
                     emit.count = 2'd1;
                     emit.first = tbs_pkg::make_rsp(tbs_pkg::KIND_OPER, cur_line_ff,
                                                    cur_col_ff, tbs_pkg::LEN_ONE, 1'b1);
                  end else begin
                     mode_in    = tbs_pkg::MODE_ERROR;
                     emit.count = 2'd1;
                     emit.first = tbs_pkg::make_rsp(tbs_pkg::KIND_BADCHAR, cur_line_ff,
                                                    cur_col_ff, tbs_pkg::LEN_ONE, 1'b1);
                  end
               end
            endcase

            // freeze position once an error is taken
            if (mode_in != tbs_pkg::MODE_ERROR) begin
               if (c == tbs_pkg::CHAR_LF) begin
                  cur_line_in = tbs_pkg::sat_pos(cur_line_ff);
                  cur_col_in  = tbs_pkg::POS_ONE;
               end else begin
                  cur_col_in = tbs_pkg::sat_pos(cur_col_ff);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= tbs_pkg::MODE_IDLE;
         quote_single_ff <= 1'b0;
         prefix_ff       <= tbs_pkg::PREFIX_PLAIN;
         tok_line_ff     <= tbs_pkg::POS_ONE;
         tok_col_ff      <= tbs_pkg::POS_ONE;
         tok_len_ff      <= '0;
         cur_line_ff     <= tbs_pkg::POS_ONE;
         cur_col_ff      <= tbs_pkg::POS_ONE;
      end else begin
         mode_ff         <= mode_in;
         quote_single_ff <= quote_single_in;
         prefix_ff       <= prefix_in;
         tok_line_ff     <= tok_line_in;
         tok_col_ff      <= tok_col_in;
         tok_len_ff      <= tok_len_in;
         cur_line_ff     <= cur_line_in;
         cur_col_ff      <= cur_col_in;
      end
   end

endmodule

// ===== hdl/tbs_rsp_fifo.sv =====
// Result queue for the token boundary scanner: takes up to two results a cycle, hands out
// one a cycle while rsp_stall is low. Depends on tbs_pkg for the result and emit types.
module tbs_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  tbs_pkg::emit_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tbs_pkg::rsp_type  rsp_payload
);

   tbs_pkg::rsp_type                  entry_ff [tbs_pkg::QUEUE_DEPTH];
   logic [tbs_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tbs_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tbs_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [tbs_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_next;
   logic                               pop;

   // keep space for a two-result request regardless of the output side
   assign room        = (count_ff <= tbs_pkg::QUEUE_CNT_BITS'(tbs_pkg::QUEUE_DEPTH - 2));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + tbs_pkg::QUEUE_PTR_BITS'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + tbs_pkg::QUEUE_CNT_BITS'(push.count)
                  - tbs_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== tb/sv/token_boundary_scanner_tb.sv =====
// Self-checking bench for token_boundary_scanner: directed table, random token streams
// and a closing lexical error, all scored against a predictor.
// Depends on tbs_pkg and the RTL in hdl/.
module token_boundary_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbs_pkg::*;

   localparam int RANDOM_ITEMS = 700;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic [KIND_BITS-1:0] KIND_LABEL   = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_BUILTIN = 4'd5;

   localparam logic [127:0] OPER_CHARS  = "&|!-+/%*()[]$<>~";
   localparam logic [47:0]  BLANK_CHARS = {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
      logic       typed;
      logic [1:0] count;
      rsp_type    t0;
      rsp_type    t1;
   } stim_row;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // scanner state as predicted
   logic [MODE_BITS-1:0] scan_state = MODE_IDLE;
   logic                 quote_is_single = 1'b0;
   logic [1:0]           id_prefix = PREFIX_PLAIN;
   logic [POS_BITS-1:0]  tok_line = POS_ONE;
   logic [POS_BITS-1:0]  tok_col = POS_ONE;
   logic [LEN_BITS-1:0]  tok_len = '0;
   logic [POS_BITS-1:0]  pos_line = POS_ONE;
   logic [POS_BITS-1:0]  pos_col = POS_ONE;

   rsp_type pending_tokens [$];
   stim_row directed_rows [$];
   rsp_type want;
   int      mismatches = 0;
   int      live_items = 0;
   int      cycle_count;
   int      stall_left = 0;
   int      stall_pick;
   bit      req_quiet = 1'b0;
   bit      rsp_quiet = 1'b0;
   bit      hold_rsp = 1'b0;

   token_boundary_scanner i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit blank_ch(input logic [7:0] c);
      for (int i = 0; i < 6; i++) begin
         if (BLANK_CHARS[8*i +: 8] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit oper_ch(input logic [7:0] c);
      for (int i = 0; i < 16; i++) begin
         if (OPER_CHARS[8*i +: 8] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit digit_ch(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit letter_ch(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [POS_BITS-1:0] next_pos(input logic [POS_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LEN_BITS-1:0] next_len(input logic [LEN_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic rsp_type token_rec(input logic [KIND_BITS-1:0] kind,
                                         input logic [POS_BITS-1:0] line,
                                         input logic [POS_BITS-1:0] col,
                                         input logic [LEN_BITS-1:0] len,
                                         input logic last);
      rsp_type r;
      r.token_kind   = kind;
      r.start_line   = line;
      r.start_column = col;
      r.token_length = len;
      r.last_of_run  = last;
      return r;
   endfunction

   task automatic mark_start(input logic [MODE_BITS-1:0] next_state);
      scan_state = next_state;
      tok_line   = pos_line;
      tok_col    = pos_col;
      tok_len    = LEN_ONE;
   endtask

   // Advance the predicted scanner by one request; return the tokens it finishes.
   task automatic scan_char(input logic [7:0] c, input logic e, output int n,
                            output rsp_type o0, output rsp_type o1);
      rsp_type              outs [2];
      logic [KIND_BITS-1:0] word_kind;
      n = 0;
      outs[0] = '0;
      outs[1] = '0;
      word_kind = (scan_state == MODE_INT)        ? KIND_INT :
                  (scan_state == MODE_FLOAT)      ? KIND_FLOAT :
                  (id_prefix == PREFIX_LABEL)     ? KIND_LABEL :
                  (id_prefix == PREFIX_BUILTIN)   ? KIND_BUILTIN : KIND_IDENT;
      if (scan_state != MODE_ERROR) begin
         if (e) begin
            if (scan_state == MODE_INT || scan_state == MODE_FLOAT
                || scan_state == MODE_IDENT) begin
               outs[n] = token_rec(word_kind, tok_line, tok_col, tok_len, 1'b0);
               n++;
               scan_state = MODE_IDLE;
            end else if (scan_state == MODE_STRING || scan_state == MODE_ESCAPE) begin
               outs[n] = token_rec(KIND_UNCLOSED, tok_line, tok_col, tok_len, 1'b0);
               n++;
               scan_state = MODE_ERROR;
            end else begin
               scan_state = MODE_IDLE;
            end
         end else begin
            case (scan_state)
               MODE_INT, MODE_FLOAT, MODE_IDENT: begin
                  if (blank_ch(c) || oper_ch(c)) begin
                     outs[n] = token_rec(word_kind, tok_line, tok_col, tok_len, 1'b0);
                     n++;
                     scan_state = MODE_IDLE;
                     if (oper_ch(c)) begin
                        outs[n] = token_rec(KIND_OPER, pos_line, pos_col, LEN_ONE, 1'b0);
                        n++;
                     end
                  end else if (scan_state == MODE_IDENT
                               ? (digit_ch(c) || letter_ch(c) || c == CHAR_UNDERLINE)
                               : digit_ch(c)) begin
                     tok_len = next_len(tok_len);
                  end else if (scan_state == MODE_INT && c == CHAR_DOT) begin
                     tok_len = next_len(tok_len);
                     scan_state = MODE_FLOAT;
                  end else begin
                     tok_len = next_len(tok_len);
                     outs[n] = token_rec(scan_state == MODE_IDENT ? KIND_IDERR : KIND_NUMERR,
                                         tok_line, tok_col, tok_len, 1'b0);
                     n++;
                     scan_state = MODE_ERROR;
                  end
               end
               MODE_STRING: begin
                  if (c == CHAR_BACKSLASH) begin
                     scan_state = MODE_ESCAPE;
                  end else begin
                     tok_len = next_len(tok_len);
                     if (c == (quote_is_single ? CHAR_SQUOTE : CHAR_DQUOTE)) begin
                        outs[n] = token_rec(KIND_STRING, tok_line, tok_col, tok_len, 1'b0);
                        n++;
                        scan_state = MODE_IDLE;
                     end
                  end
               end
               MODE_ESCAPE: begin
                  tok_len = next_len(tok_len);
                  scan_state = MODE_STRING;
               end
               MODE_LCOMMENT: begin
                  if (c == CHAR_LF) scan_state = MODE_IDLE;
               end
               MODE_BCOMMENT: begin
                  if (c == CHAR_QUESTION) scan_state = MODE_IDLE;
               end
               default: begin
                  if (blank_ch(c)) begin
                     scan_state = MODE_IDLE;
                  end else if (c == CHAR_HASH) begin
                     scan_state = MODE_LCOMMENT;
                  end else if (c == CHAR_QUESTION) begin
                     scan_state = MODE_BCOMMENT;
                  end else if (digit_ch(c)) begin
                     mark_start(MODE_INT);
                  end else if (letter_ch(c) || c == CHAR_AT || c == CHAR_UNDERLINE) begin
                     mark_start(MODE_IDENT);
                     id_prefix = (c == CHAR_AT) ? PREFIX_LABEL :
                                 (c == CHAR_UNDERLINE) ? PREFIX_BUILTIN : PREFIX_PLAIN;
                  end else if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
                     mark_start(MODE_STRING);
                     quote_is_single = (c == CHAR_SQUOTE);
                  end else if (oper_ch(c)) begin
                     scan_state = MODE_IDLE;
                     outs[n] = token_rec(KIND_OPER, pos_line, pos_col, LEN_ONE, 1'b0);
                     n++;
                  end else begin
                     scan_state = MODE_ERROR;
                     outs[n] = token_rec(KIND_BADCHAR, pos_line, pos_col, LEN_ONE, 1'b0);
                     n++;
                  end
               end
            endcase
            // positions freeze once an error has been reported
            if (scan_state != MODE_ERROR) begin
               if (c == CHAR_LF) begin
                  pos_line = next_pos(pos_line);
                  pos_col  = POS_ONE;
               end else begin
                  pos_col = next_pos(pos_col);
               end
            end
         end
      end
      if (n > 0) outs[n-1].last_of_run = 1'b1;
      o0 = outs[0];
      o1 = outs[1];
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (hold_rsp || req_quiet || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic e, input logic typed,
                            input logic [1:0] count, input rsp_type t0, input rsp_type t1);
      int      n;
      int      gap;
      rsp_type p0;
      rsp_type p1;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.char_in <= c;
      req_payload.end_of_input <= e;
      do @(posedge clock); while (req_stall);
      if (scan_state != MODE_ERROR && !(e && scan_state == MODE_IDLE)) live_items++;
      scan_char(c, e, n, p0, p1);
      if (typed) begin
         n  = int'(count);
         p0 = t0;
         p1 = t1;
      end
      if (n > 0) pending_tokens.push_back(p0);
      if (n > 1) pending_tokens.push_back(p1);
      if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
   endtask

   task automatic put(input logic [7:0] c);
      send_char(c, 1'b0, 1'b0, 2'd0, '0, '0);
   endtask

   task automatic put_end();
      send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, 2'd0, '0, '0);
   endtask

   task automatic plain_row(input logic [7:0] c, input logic e);
      stim_row r;
      r = '0;
      r.ch = c;
      r.eoi = e;
      directed_rows.push_back(r);
   endtask

   task automatic typed_row(input logic [7:0] c, input logic e, input logic [1:0] count,
                            input rsp_type t0, input rsp_type t1);
      stim_row r;
      r.ch = c;
      r.eoi = e;
      r.typed = 1'b1;
      r.count = count;
      r.t0 = t0;
      r.t1 = t1;
      directed_rows.push_back(r);
   endtask

   function automatic logic [7:0] any_blank();
      return BLANK_CHARS[8*$urandom_range(0, 5) +: 8];
   endfunction

   function automatic logic [7:0] any_oper();
      return OPER_CHARS[8*$urandom_range(0, 15) +: 8];
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] any_letter();
      return 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] any_word_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return any_letter();
      if (r < 9) return any_digit();
      return CHAR_UNDERLINE;
   endfunction

   task automatic put_separator();
      int r;
      r = $urandom_range(0, 19);
      if (r < 9) put(any_blank());
      else if (r < 18) put(any_oper());
      else put_end();
   endtask

   task automatic put_number(input int digits, input bit dot, input int frac);
      repeat (digits) put(any_digit());
      if (dot) begin
         put(CHAR_DOT);
         repeat (frac) put(any_digit());
      end
   endtask

   task automatic put_ident(input int tail);
      int r;
      r = $urandom_range(0, 5);
      put(r == 0 ? CHAR_AT : r == 1 ? CHAR_UNDERLINE : any_letter());
      repeat (tail) put(any_word_char());
   endtask

   task automatic put_string(input int content, input bit closed);
      logic [7:0] q;
      logic [7:0] b;
      q = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
      put(q);
      repeat (content) begin
         b = 8'($urandom_range(0, 255));
         if (b == q || b == CHAR_BACKSLASH || $urandom_range(0, 9) == 0) put(CHAR_BACKSLASH);
         put(b);
      end
      if (closed) begin
         put(q);
      end else begin
         if ($urandom_range(0, 1)) put(CHAR_BACKSLASH);
         put_end();
      end
   endtask

   task automatic put_comment(input bit block, input int content);
      logic [7:0] term;
      logic [7:0] b;
      term = block ? CHAR_QUESTION : CHAR_LF;
      put(block ? CHAR_QUESTION : CHAR_HASH);
      repeat (content) begin
         do b = 8'($urandom_range(0, 255)); while (b == term);
         put(b);
      end
      if ($urandom_range(0, 7) == 0) put_end();
      else put(term);
   endtask

   // stimulus
   initial begin
      stim_row    row;
      int         pick;
      int         start;
      logic [7:0] b;

      typed_row("+", 1'b0, 2'd2,
                token_rec(KIND_INT, POS_BITS'(1), POS_BITS'(1), LEN_BITS'(1), 1'b0),
                token_rec(KIND_OPER, POS_BITS'(1), POS_BITS'(2), LEN_BITS'(1), 1'b1));
      directed_rows.push_front('{ch: "7", eoi: 1'b0, typed: 1'b0, count: 2'd0,
                                 t0: '0, t1: '0});
      plain_row("3", 1'b0);
      plain_row(CHAR_DOT, 1'b0);
      plain_row("5", 1'b0);
      typed_row(8'hA5, 1'b1, 2'd1,
                token_rec(KIND_FLOAT, POS_BITS'(1), POS_BITS'(3), LEN_BITS'(3), 1'b1), '0);
      plain_row(" ", 1'b0);
      plain_row(CHAR_AT, 1'b0);
      plain_row("x", 1'b0);
      typed_row(8'h09, 1'b0, 2'd1,
                token_rec(KIND_LABEL, POS_BITS'(1), POS_BITS'(7), LEN_BITS'(2), 1'b1), '0);
      plain_row(CHAR_UNDERLINE, 1'b0);
      typed_row("~", 1'b0, 2'd2,
                token_rec(KIND_BUILTIN, POS_BITS'(1), POS_BITS'(10), LEN_BITS'(1), 1'b0),
                token_rec(KIND_OPER, POS_BITS'(1), POS_BITS'(11), LEN_BITS'(1), 1'b1));
      // single-quoted string with an escaped quote, a high byte and a foreign quote
      plain_row(CHAR_SQUOTE, 1'b0);
      plain_row(CHAR_BACKSLASH, 1'b0);
      plain_row(CHAR_SQUOTE, 1'b0);
      plain_row(8'hFF, 1'b0);
      plain_row(CHAR_DQUOTE, 1'b0);
      typed_row(CHAR_SQUOTE, 1'b0, 2'd1,
                token_rec(KIND_STRING, POS_BITS'(1), POS_BITS'(12), LEN_BITS'(5), 1'b1), '0);
      // end of input inside a comment, then in idle
      plain_row(CHAR_HASH, 1'b0);
      plain_row(8'hFF, 1'b0);
      plain_row(8'h00, 1'b1);
      plain_row(8'hFF, 1'b1);
      plain_row(CHAR_QUESTION, 1'b0);
      plain_row(CHAR_LF, 1'b0);
      plain_row(CHAR_QUESTION, 1'b0);
      plain_row("0", 1'b0);
      typed_row(CHAR_LF, 1'b0, 2'd1,
                token_rec(KIND_INT, POS_BITS'(2), POS_BITS'(2), LEN_BITS'(1), 1'b1), '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_char(row.ch, row.eoi, row.typed, row.count, row.t0, row.t1);
      end

      start = live_items;
      while (live_items - start < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 4) begin
            put_number($urandom_range(1, 4), $urandom_range(0, 2) == 0, $urandom_range(0, 3));
            put_separator();
         end else if (pick < 8) begin
            put_ident($urandom_range(0, 6));
            put_separator();
         end else if (pick < 11) begin
            put_string($urandom_range(0, 8), 1'b1);
         end else if (pick < 13) begin
            put(any_oper());
         end else if (pick < 15) begin
            put(any_blank());
         end else if (pick == 15) begin
            put_comment(1'b0, $urandom_range(0, 8));
         end else if (pick == 16) begin
            put_comment(1'b1, $urandom_range(0, 8));
         end else if (pick == 17) begin
            put_end();
         end else if (pick == 18) begin
            if ($urandom_range(0, 1)) begin
               put_number($urandom_range(10, 40), $urandom_range(0, 1), $urandom_range(0, 10));
            end else begin
               put_ident($urandom_range(10, 40));
            end
            put_separator();
         end else begin
            put(CHAR_LF);
         end
      end

      // one lexical error, after which the block goes silent
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
         do b = 8'($urandom_range(0, 255));
         while (blank_ch(b) || oper_ch(b) || digit_ch(b) || letter_ch(b) || b == CHAR_HASH
                || b == CHAR_QUESTION || b == CHAR_AT || b == CHAR_UNDERLINE
                || b == CHAR_SQUOTE || b == CHAR_DQUOTE);
         put(b);
      end else if (pick == 1) begin
         put_number($urandom_range(1, 3), 1'b1, $urandom_range(0, 2));
         if ($urandom_range(0, 1)) begin
            put(CHAR_DOT);
         end else begin
            do b = 8'($urandom_range(0, 255));
            while (blank_ch(b) || oper_ch(b) || digit_ch(b) || b == CHAR_DOT);
            put(b);
         end
      end else if (pick == 2) begin
         put_ident($urandom_range(0, 4));
         do b = 8'($urandom_range(0, 255));
         while (blank_ch(b) || oper_ch(b) || digit_ch(b) || letter_ch(b)
                || b == CHAR_UNDERLINE);
         put(b);
      end else begin
         put_string($urandom_range(0, 5), 1'b0);
      end
      repeat (8) begin
         if ($urandom_range(0, 3) == 0) put_end();
         else put(8'($urandom_range(0, 255)));
      end

      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hold the result side off long enough to back the block up into its input
   initial begin
      while (live_items < 300) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected token: kind %0d, line %0d, column %0d, length %0d",
                   rsp_payload.token_kind, rsp_payload.start_line,
                   rsp_payload.start_column, rsp_payload.token_length);
            mismatches++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_payload.token_kind !== want.token_kind) begin
               $error("token_kind: expected %0d, got %0d",
                      want.token_kind, rsp_payload.token_kind);
               mismatches++;
            end
            if (rsp_payload.start_line !== want.start_line) begin
               $error("start_line: expected %0d, got %0d",
                      want.start_line, rsp_payload.start_line);
               mismatches++;
            end
            if (rsp_payload.start_column !== want.start_column) begin
               $error("start_column: expected %0d, got %0d",
                      want.start_column, rsp_payload.start_column);
               mismatches++;
            end
            if (rsp_payload.token_length !== want.token_length) begin
               $error("token_length: expected %0d, got %0d",
                      want.token_length, rsp_payload.token_length);
               mismatches++;
            end
            if (rsp_payload.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                      want.last_of_run, rsp_payload.last_of_run);
               mismatches++;
            end
         end
      end

      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (rsp_quiet || stall_pick >= 20) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= (stall_pick < 17) ? $urandom_range(0, 2) : $urandom_range(10, 40);
         end
      end
      if ($urandom_range(0, 199) == 0) rsp_quiet <= !rsp_quiet;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tbs_pkg.sv
hdl/tbs_core.sv
hdl/tbs_rsp_fifo.sv
hdl/token_boundary_scanner.sv
tb/sv/token_boundary_scanner_tb.sv
